/* rtl/core/ef3_pkg.sv */
`timescale 1ns / 1ps
package ef3_pkg;

    localparam int PIX_W     = 8;
    localparam int MAG_W     = 11;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int KSEL_W    = 3;
    localparam int WT_W      = 5;
    localparam int SUM_W     = 14;
    localparam int DIM_MIN   = 3;
    localparam int DIM_RST   = 512;
    // result queue depth, power of two so the pointers wrap by themselves
    localparam int OQ_DEPTH  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KSEL   = 2'd2;

    localparam logic [KSEL_W-1:0] KSEL_SOBEL_H   = 3'd0;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_V   = 3'd1;
    localparam logic [KSEL_W-1:0] KSEL_PREWITT_H = 3'd2;
    localparam logic [KSEL_W-1:0] KSEL_PREWITT_V = 3'd3;
    localparam logic [KSEL_W-1:0] KSEL_LAPLACE   = 3'd4;

    // kernels, row-major, row 0 on top, column 0 the oldest
    localparam logic signed [WT_W-1:0] K_SOBEL_H [9] = '{
        5'sd1, 5'sd2, 5'sd1, 5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd2, -5'sd1};
    localparam logic signed [WT_W-1:0] K_SOBEL_V [9] = '{
        -5'sd1, 5'sd0, 5'sd1, -5'sd2, 5'sd0, 5'sd2, -5'sd1, 5'sd0, 5'sd1};
    localparam logic signed [WT_W-1:0] K_PREWITT_H [9] = '{
        5'sd1, 5'sd1, 5'sd1, 5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd1, -5'sd1};
    localparam logic signed [WT_W-1:0] K_PREWITT_V [9] = '{
        -5'sd1, 5'sd0, 5'sd1, -5'sd1, 5'sd0, 5'sd1, -5'sd1, 5'sd0, 5'sd1};
    localparam logic signed [WT_W-1:0] K_LAPLACE [9] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1};

    // unused codes fall back to the laplacian
    function automatic logic signed [WT_W-1:0] kernel_weight(
        input logic [KSEL_W-1:0] ksel,
        input logic [3:0]        idx
    );
        logic signed [WT_W-1:0] w;
        unique case (ksel)
            KSEL_SOBEL_H:   w = K_SOBEL_H[idx];
            KSEL_SOBEL_V:   w = K_SOBEL_V[idx];
            KSEL_PREWITT_H: w = K_PREWITT_H[idx];
            KSEL_PREWITT_V: w = K_PREWITT_V[idx];
            default:        w = K_LAPLACE[idx];
        endcase
        return w;
    endfunction

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic col0;       // first column: window history is zero
        logic has_top;    // row two above lies inside the image
        logic has_mid;    // row one above lies inside the image
        logic res0;       // result for the left neighbor of the new column
        logic res1;       // extra result for the right image column
        logic frame_end;  // padding row: extra result closes the frame
    } t_item_flags;

    // one queue entry holds the one or two results of one item
    typedef struct packed {
        logic             two;
        logic [MAG_W-1:0] mag0;
        logic             fe0;
        logic [MAG_W-1:0] mag1;
        logic             fe1;
    } t_oq_entry;

endpackage

/* rtl/core/ef3_line_buf.sv */
`timescale 1ns / 1ps
module ef3_line_buf
    import ef3_pkg::*;
#(
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [PIX_W-1:0]         i_pixel,
    input  t_item_flags              i_flags,
    output logic                     o_valid,
    output logic [PIX_W-1:0]         o_top,
    output logic [PIX_W-1:0]         o_mid,
    output logic [PIX_W-1:0]         o_bot,
    output t_item_flags              o_flags
);

    localparam int ADDR_W = $clog2(DEPTH);

    // word = {two rows above, one row above}
    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_rdata;
    logic               r_valid;
    logic [ADDR_W-1:0]  r_addr;
    logic [PIX_W-1:0]   r_pixel;
    t_item_flags        r_flags;

    logic               wr_en;
    logic [2*PIX_W-1:0] wr_data;

    // write back in the cycle after the read: rows move up by one
    assign wr_en   = r_valid;
    assign wr_data = {r_rdata[PIX_W-1:0], r_pixel};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
    end

    // forward the pending write on an address match
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (wr_en && (r_addr == i_rd_addr)) begin
                r_rdata <= wr_data;
            end else begin
                r_rdata <= r_mem[i_rd_addr];
            end
            r_addr  <= i_rd_addr;
            r_pixel <= i_pixel;
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_rd_en;
        end
    end

    assign o_valid = r_valid;
    assign o_top   = r_flags.has_top ? r_rdata[2*PIX_W-1:PIX_W] : '0;
    assign o_mid   = r_flags.has_mid ? r_rdata[PIX_W-1:0] : '0;
    assign o_bot   = r_pixel;
    assign o_flags = r_flags;

endmodule

/* rtl/core/ef3_window_alu.sv */
`timescale 1ns / 1ps
module ef3_window_alu
    import ef3_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [PIX_W-1:0]        i_top,
    input  logic [PIX_W-1:0]        i_mid,
    input  logic [PIX_W-1:0]        i_bot,
    input  t_item_flags             i_flags,
    input  logic [KSEL_W-1:0]       i_ksel,
    output logic                    o_valid,
    output logic signed [SUM_W-1:0] o_sum0,
    output logic signed [SUM_W-1:0] o_sum1,
    output t_item_flags             o_flags
);

    function automatic logic signed [SUM_W-1:0] wterm(
        input logic signed [WT_W-1:0] w,
        input logic [PIX_W-1:0]       p
    );
        logic signed [SUM_W-1:0] ws;
        logic signed [SUM_W-1:0] ps;
        ws = SUM_W'(w);
        ps = $signed(SUM_W'(p));
        return ws * ps;
    endfunction

    // two newest columns, row 0 on top
    logic [PIX_W-1:0] r_hist_a [3];
    logic [PIX_W-1:0] r_hist_b [3];
    // registered window, index row*3 + column
    logic [PIX_W-1:0] r_win [9];
    logic             r_win_valid;
    t_item_flags      r_win_flags;

    logic [PIX_W-1:0] col_new  [3];
    logic [PIX_W-1:0] col_left [3];
    logic [PIX_W-1:0] col_mid  [3];

    logic signed [WT_W-1:0]  wt [9];
    logic signed [SUM_W-1:0] n_sum0;
    logic signed [SUM_W-1:0] n_sum1;
    logic signed [SUM_W-1:0] row0 [3];
    logic signed [SUM_W-1:0] row1 [3];

    logic signed [SUM_W-1:0] r_sum0;
    logic signed [SUM_W-1:0] r_sum1;
    logic                    r_sum_valid;
    t_item_flags             r_sum_flags;

    assign col_new[0] = i_top;
    assign col_new[1] = i_mid;
    assign col_new[2] = i_bot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            col_left[i] = i_flags.col0 ? '0 : r_hist_a[i];
            col_mid[i]  = i_flags.col0 ? '0 : r_hist_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_hist_a[i] <= '0;
                r_hist_b[i] <= '0;
            end
        end else if (i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_hist_a[i] <= col_mid[i];
                r_hist_b[i] <= col_new[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[3*i]     <= col_left[i];
                r_win[3*i + 1] <= col_mid[i];
                r_win[3*i + 2] <= col_new[i];
            end
            r_win_flags <= i_flags;
        end
    end

    // sum0: full window; sum1: window shifted once more with a zero column
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            wt[k] = kernel_weight(i_ksel, 4'(k));
        end
        for (int i = 0; i < 3; i++) begin
            row0[i] = wterm(wt[3*i], r_win[3*i]) + wterm(wt[3*i + 1], r_win[3*i + 1])
                    + wterm(wt[3*i + 2], r_win[3*i + 2]);
            row1[i] = wterm(wt[3*i], r_win[3*i + 1]) + wterm(wt[3*i + 1], r_win[3*i + 2]);
        end
        n_sum0 = row0[0] + row0[1] + row0[2];
        n_sum1 = row1[0] + row1[1] + row1[2];
    end

    always_ff @(posedge i_clk) begin
        if (r_win_valid) begin
            r_sum0      <= n_sum0;
            r_sum1      <= n_sum1;
            r_sum_flags <= r_win_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid <= 1'b0;
            r_sum_valid <= 1'b0;
        end else begin
            r_win_valid <= i_valid;
            r_sum_valid <= r_win_valid;
        end
    end

    assign o_valid = r_sum_valid;
    assign o_sum0  = r_sum0;
    assign o_sum1  = r_sum1;
    assign o_flags = r_sum_flags;

endmodule

/* rtl/core/ef3_out_queue.sv */
`timescale 1ns / 1ps
module ef3_out_queue
    import ef3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_oq_entry        i_entry,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [MAG_W-1:0] o_magnitude,
    output logic             o_frame_end,
    output logic             o_pop
);

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    t_oq_entry        r_mem [OQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_half;   // second result of the head entry is up

    t_oq_entry        head;
    logic             xfer;
    logic [CNT_W-1:0] n_count;

    assign head        = r_mem[r_rd_ptr];
    assign o_valid     = (r_count != '0);
    assign o_magnitude = r_half ? head.mag1 : head.mag0;
    assign o_frame_end = r_half ? head.fe1 : head.fe0;
    assign xfer        = o_valid & i_ready;
    assign o_pop       = xfer & (r_half | ~head.two);

    always_comb begin
        n_count = r_count;
        if (i_push && !o_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && o_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_half   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (o_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                r_half   <= 1'b0;
            end else if (xfer) begin
                r_half   <= 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* rtl/core/edge_filter_3x3_core.sv */
`timescale 1ns / 1ps
// Each transfer passes the line-store read, window and sum registers into the queue.
// Throughput: 1 pixel per cycle while o_ready is high; the line-store read at transfer and
//   the write-back in the following cycle hit different columns, so pixels stream freely.
// Results leave at 1 per cycle while i_ready is high, from an 8-entry queue; a row end gives 2.
// Reset: synchronous, active low; clears position, pipeline and queue and
//   loads width 512, height 512, laplacian. Line stores are not cleared.
module edge_filter_3x3_core
    import ef3_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // pixel stream in
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_pad_tick,
    // result stream out
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MAG_W-1:0]     o_magnitude,
    output logic                 o_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WX_W  = (CFG_W > EW_W) ? CFG_W : EW_W;
    localparam int HX_W  = (CFG_W > EH_W) ? CFG_W : EH_W;
    localparam int EW_RST = (DIM_RST > MAX_WIDTH) ? MAX_WIDTH : DIM_RST;
    localparam int EH_RST = (DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RST;
    localparam int CR_W  = $clog2(OQ_DEPTH + 1);

    // ---------------------------------------------------------------
    // Configuration: dimensions are clamped as they are written
    // ---------------------------------------------------------------
    logic [EW_W-1:0]   r_ew;
    logic [EH_W-1:0]   r_eh;
    logic [KSEL_W-1:0] r_ksel;
    logic [EW_W-1:0]   n_ew;
    logic [EH_W-1:0]   n_eh;
    logic [WX_W-1:0]   wx;
    logic [HX_W-1:0]   hx;

    always_comb begin
        wx = WX_W'(i_cfg_data);
        hx = HX_W'(i_cfg_data);
        if (wx < WX_W'(DIM_MIN)) begin
            n_ew = EW_W'(DIM_MIN);
        end else if (wx > WX_W'(MAX_WIDTH)) begin
            n_ew = EW_W'(MAX_WIDTH);
        end else begin
            n_ew = EW_W'(wx);
        end
        if (hx < HX_W'(DIM_MIN)) begin
            n_eh = EH_W'(DIM_MIN);
        end else if (hx > HX_W'(MAX_HEIGHT)) begin
            n_eh = EH_W'(MAX_HEIGHT);
        end else begin
            n_eh = EH_W'(hx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew   <= EW_W'(EW_RST);
            r_eh   <= EH_W'(EH_RST);
            r_ksel <= KSEL_LAPLACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_ew   <= n_ew;
                CFG_IDX_HEIGHT: r_eh   <= n_eh;
                CFG_IDX_KSEL:   r_ksel <= i_cfg_data[KSEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input position and per-item decode
    // ---------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [EH_W-1:0]  r_row;     // equals height during the padding row
    logic             in_xfer;
    logic             pad_row;
    logic             last_col;
    logic [PIX_W-1:0] pix_v;
    t_item_flags      in_flags;

    assign in_xfer  = i_valid & o_ready;
    assign pad_row  = (r_row >= r_eh);
    assign pix_v    = (pad_row | i_pad_tick) ? '0 : i_pixel;
    assign last_col = ((EW_W + 1)'(r_col) + (EW_W + 1)'(1)) >= (EW_W + 1)'(r_ew);

    always_comb begin
        in_flags.col0      = (r_col == '0);
        in_flags.has_top   = (r_row >= EH_W'(2));
        in_flags.has_mid   = (r_row != '0);
        in_flags.res0      = (r_row != '0) && (r_col != '0);
        in_flags.res1      = (r_row != '0) && last_col;
        in_flags.frame_end = pad_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= pad_row ? '0 : r_row + EH_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Line stores: read at transfer, write back the shifted column
    // ---------------------------------------------------------------
    logic             lb_valid;
    logic [PIX_W-1:0] lb_top;
    logic [PIX_W-1:0] lb_mid;
    logic [PIX_W-1:0] lb_bot;
    t_item_flags      lb_flags;

    ef3_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (r_col),
        .i_pixel   (pix_v),
        .i_flags   (in_flags),
        .o_valid   (lb_valid),
        .o_top     (lb_top),
        .o_mid     (lb_mid),
        .o_bot     (lb_bot),
        .o_flags   (lb_flags)
    );

    // ---------------------------------------------------------------
    // Window and kernel sums
    // ---------------------------------------------------------------
    logic                    alu_valid;
    logic signed [SUM_W-1:0] alu_sum0;
    logic signed [SUM_W-1:0] alu_sum1;
    t_item_flags             alu_flags;

    ef3_window_alu u_window_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lb_valid),
        .i_top   (lb_top),
        .i_mid   (lb_mid),
        .i_bot   (lb_bot),
        .i_flags (lb_flags),
        .i_ksel  (r_ksel),
        .o_valid (alu_valid),
        .o_sum0  (alu_sum0),
        .o_sum1  (alu_sum1),
        .o_flags (alu_flags)
    );

    // ---------------------------------------------------------------
    // Magnitudes into the result queue
    // ---------------------------------------------------------------
    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] a;
        a = (s < 0) ? -s : s;
        return a[MAG_W-1:0];
    endfunction

    logic      oq_push;
    logic      oq_pop;
    t_oq_entry oq_entry;

    assign oq_push = alu_valid & (alu_flags.res0 | alu_flags.res1);

    always_comb begin
        oq_entry.two  = alu_flags.res0 & alu_flags.res1;
        oq_entry.mag0 = alu_flags.res0 ? abs_mag(alu_sum0) : abs_mag(alu_sum1);
        oq_entry.fe0  = alu_flags.res0 ? 1'b0 : alu_flags.frame_end;
        oq_entry.mag1 = abs_mag(alu_sum1);
        oq_entry.fe1  = alu_flags.frame_end;
    end

    ef3_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (oq_push),
        .i_entry     (oq_entry),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_frame_end (o_frame_end),
        .o_pop       (oq_pop)
    );

    // ---------------------------------------------------------------
    // Credit: queue entries held or claimed by items still in flight.
    // An item that yields results claims one entry at its transfer, so
    // the queue can never overflow however long the output stalls.
    // ---------------------------------------------------------------
    logic [CR_W-1:0] r_credit;
    logic            claim;

    assign claim   = in_xfer & (in_flags.res0 | in_flags.res1);
    assign o_ready = (r_credit < CR_W'(OQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (claim && !oq_pop) begin
            r_credit <= r_credit + CR_W'(1);
        end else if (!claim && oq_pop) begin
            r_credit <= r_credit - CR_W'(1);
        end
    end

endmodule
